@@ rtl/core/nnsa_pkg.sv @@
// Shared constants and controller/datapath interface types for the scaling address generator.
package nnsa_pkg;

  localparam int unsigned REG_W           = 12;
  localparam int unsigned IDX_W           = 22;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned MAX_DIM_DEFAULT = 2048;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // item taken: apply restart
    logic mul;       // register products and step flags
    logic emit;      // write output register, advance counters, start divide
    logic div_step;  // one quotient bit
    logic wb;        // fold quotient and remainder into the accumulators
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;  // output register can take an item this cycle
    logic need_div;   // current item advances a column or a row
    logic div_last;   // divider is on its final step
  } sts_t;

endpackage

@@ rtl/core/nnsa_div.sv @@
// Restoring divider, one quotient bit per cycle while step_i is high, for the accumulators.
module nnsa_div #(
  parameter int unsigned DIM_W = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             step_i,
  input  logic [DIM_W:0]   dividend_i,
  input  logic [DIM_W-1:0] divisor_i,
  output logic [DIM_W:0]   quot_o,
  output logic [DIM_W-1:0] rem_o,
  output logic             last_o
);

  localparam int unsigned SUM_W = DIM_W + 1;
  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  logic [DIM_W-1:0] pr_q, pr_d;
  logic [SUM_W-1:0] qd_q;
  logic [DIM_W-1:0] dv_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0] trial;
  logic [SUM_W-1:0] diff;
  logic             ge;

  // Partial remainder stays below the divisor, so the shifted trial fits SUM_W bits.
  assign trial = {pr_q, qd_q[SUM_W-1]};
  assign diff  = trial - {1'b0, dv_q};
  assign ge    = (trial >= {1'b0, dv_q});
  assign pr_d  = ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(SUM_W);
    end else if (step_i) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      pr_q <= '0;
      qd_q <= dividend_i;
      dv_q <= divisor_i;
    end else if (step_i) begin
      pr_q <= pr_d;
      qd_q <= {qd_q[SUM_W-2:0], ge};
    end
  end

  assign quot_o = qd_q;
  assign rem_o  = pr_q;
  assign last_o = (cnt_q == CNT_W'(1));

endmodule

@@ rtl/core/nnsa_dp.sv @@
// Datapath: size registers, raster and source accumulators, index products, output register.
module nnsa_dp #(
  parameter int unsigned MAX_DIM = nnsa_pkg::MAX_DIM_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nnsa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [nnsa_pkg::REG_W-1:0]     cfg_data_i,
  input  logic                           restart_i,
  input  nnsa_pkg::cmd_t                 cmd_i,
  output nnsa_pkg::sts_t                 sts_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           valid_res_o,
  output logic [nnsa_pkg::IDX_W-1:0]     src_index_o,
  output logic [nnsa_pkg::IDX_W-1:0]     dst_index_o,
  output logic                           last_o
);

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned EXT_W = DIM_W + 1;
  localparam int unsigned IDX_W = nnsa_pkg::IDX_W;
  localparam int unsigned REG_W = nnsa_pkg::REG_W;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [REG_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(v);
  endfunction

  logic [REG_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [DIM_W-1:0] sw, sh, dw, dh;

  logic [DIM_W-1:0] dest_col_q, dest_row_q;
  logic [DIM_W-1:0] col_rem_q, row_rem_q;
  logic [IDX_W-1:0] source_col_q, source_row_q;
  logic             frame_done_q;

  logic [IDX_W-1:0] prod_src_q, prod_dst_q;
  logic             end_col_q, end_row_q, done_q;
  logic             div_row_q;
  logic             end_col, end_row;
  logic             div_start;

  logic [EXT_W-1:0] div_dividend;
  logic [DIM_W-1:0] div_divisor;
  logic [EXT_W-1:0] div_quot;
  logic [DIM_W-1:0] div_rem;
  logic             div_last;

  logic             out_valid_q;
  logic             valid_res_q, last_q;
  logic [IDX_W-1:0] src_index_q, dst_index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= REG_W'(1);
      src_h_q <= REG_W'(1);
      dst_w_q <= REG_W'(1);
      dst_h_q <= REG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        nnsa_pkg::CFG_SRC_WIDTH:  src_w_q <= cfg_data_i;
        nnsa_pkg::CFG_SRC_HEIGHT: src_h_q <= cfg_data_i;
        nnsa_pkg::CFG_DST_WIDTH:  dst_w_q <= cfg_data_i;
        nnsa_pkg::CFG_DST_HEIGHT: dst_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sw = eff_dim(src_w_q);
  assign sh = eff_dim(src_h_q);
  assign dw = eff_dim(dst_w_q);
  assign dh = eff_dim(dst_h_q);

  assign end_col = (EXT_W'(dest_col_q) + EXT_W'(1)) >= EXT_W'(dw);
  assign end_row = (EXT_W'(dest_row_q) + EXT_W'(1)) >= EXT_W'(dh);

  // Products and step flags for the current pixel.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_src_q <= source_row_q * IDX_W'(sw);
      prod_dst_q <= IDX_W'(dest_row_q) * IDX_W'(dw);
      end_col_q  <= end_col;
      end_row_q  <= end_row;
      done_q     <= frame_done_q;
    end
  end

  assign sts_o.need_div  = !done_q && !(end_col_q && end_row_q);
  assign sts_o.slot_free = !out_valid_q || out_ready_i;
  assign sts_o.div_last  = div_last;

  assign div_start    = cmd_i.emit && sts_o.need_div;
  assign div_dividend = end_col_q ? (EXT_W'(row_rem_q) + EXT_W'(sh))
                                  : (EXT_W'(col_rem_q) + EXT_W'(sw));
  assign div_divisor  = end_col_q ? dh : dw;

  nnsa_div #(
    .DIM_W (DIM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (div_quot),
    .rem_o      (div_rem),
    .last_o     (div_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_col_q   <= '0;
      dest_row_q   <= '0;
      col_rem_q    <= '0;
      row_rem_q    <= '0;
      source_col_q <= '0;
      source_row_q <= '0;
      frame_done_q <= 1'b0;
      div_row_q    <= 1'b0;
    end else if (cmd_i.load) begin
      if (restart_i) begin
        dest_col_q   <= '0;
        dest_row_q   <= '0;
        col_rem_q    <= '0;
        row_rem_q    <= '0;
        source_col_q <= '0;
        source_row_q <= '0;
        frame_done_q <= 1'b0;
      end
    end else if (cmd_i.emit && !done_q) begin
      if (!end_col_q) begin
        dest_col_q <= dest_col_q + DIM_W'(1);
        div_row_q  <= 1'b0;
      end else begin
        dest_col_q   <= '0;
        source_col_q <= '0;
        col_rem_q    <= '0;
        if (!end_row_q) begin
          dest_row_q <= dest_row_q + DIM_W'(1);
          div_row_q  <= 1'b1;
        end else begin
          dest_row_q   <= '0;
          source_row_q <= '0;
          row_rem_q    <= '0;
          frame_done_q <= 1'b1;
        end
      end
    end else if (cmd_i.wb) begin
      if (div_row_q) begin
        source_row_q <= source_row_q + IDX_W'(div_quot);
        row_rem_q    <= div_rem;
      end else begin
        source_col_q <= source_col_q + IDX_W'(div_quot);
        col_rem_q    <= div_rem;
      end
    end
  end

  // Output register: hold the item until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      valid_res_q <= !done_q;
      src_index_q <= done_q ? '0 : prod_src_q + source_col_q;
      dst_index_q <= done_q ? '0 : prod_dst_q + IDX_W'(dest_col_q);
      last_q      <= !done_q && end_col_q && end_row_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = valid_res_q;
  assign src_index_o = src_index_q;
  assign dst_index_o = dst_index_q;
  assign last_o      = last_q;

endmodule

@@ rtl/core/nnsa_ctrl.sv @@
// Controller: per item, take, multiply, emit, then divide and write-back if needed.
module nnsa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  nnsa_pkg::sts_t sts_i,
  output nnsa_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_EMIT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        // Hold while the output register is still occupied.
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.need_div ? S_DIV : S_IDLE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/nearest_neighbour_scale_addresses.sv @@
// Top level of the nearest-neighbor scaling address generator.
//
// Usage: write src/dst width and height through the config port (index 0..3,
// values 0 act as 1, values above MAX_DIM act as MAX_DIM), then push items on
// the input channel. An item with restart_i high starts at destination pixel
// zero; with restart_i low it gives the next pixel of the raster walk. Each
// item produces exactly one output item: source index, destination index and
// a last flag on the final pixel. Once the frame is done, output items carry
// valid_res_o low and zero fields until a restart arrives.
// Once an item is taken, its products are registered in the multiply state
// and the output register is written in the emit state, which waits while
// that register is occupied. Items are paced by the bit-serial divider that
// reduces the column or row accumulator one quotient bit per cycle; an item
// with no step to take (last pixel or ended frame) skips the divide. The next
// item is taken once the divide is written back, even while the output waits.
// When the receiver stalls, the output register holds its item and the
// controller waits before emitting the next one.
// Reset: sizes return to 1, the walk returns to pixel zero, channels empty.
module nearest_neighbour_scale_addresses #(
  parameter int unsigned MAX_DIM = nnsa_pkg::MAX_DIM_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nnsa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [nnsa_pkg::REG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           restart_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           valid_res_o,
  output logic [nnsa_pkg::IDX_W-1:0]     src_index_o,
  output logic [nnsa_pkg::IDX_W-1:0]     dst_index_o,
  output logic                           last_o
);

  nnsa_pkg::cmd_t cmd;
  nnsa_pkg::sts_t sts;

  // Sequencer: one item in flight at a time.
  nnsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Accumulators, products, divider and output register.
  nnsa_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .restart_i   (restart_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .valid_res_o (valid_res_o),
    .src_index_o (src_index_o),
    .dst_index_o (dst_index_o),
    .last_o      (last_o)
  );

endmodule
